@@ rtl/bba_pkg.sv @@
// Shared constants, request/response types and control bundles for the block allocator.
package bba_pkg;

    // Pool geometry.
    localparam int NUM_BLOCKS   = 256;
    localparam int BLK_IDX_W    = $clog2(NUM_BLOCKS);
    localparam int BLOCK_SHIFT  = 4;
    localparam int BLOCK_BYTES  = 1 << BLOCK_SHIFT;
    localparam int HEADER_BYTES = 4;

    // Map bits examined per scan cycle.
    localparam int SCAN_LANES = 4;
    localparam int LANE_W     = $clog2(SCAN_LANES);
    localparam int POS_W      = BLK_IDX_W - LANE_W;

    // Field widths.
    localparam int BYTES_W  = 13;
    localparam int OFFSET_W = 12;
    localparam int COUNT_W  = 9;
    localparam int NEED_W   = 10;

    // Operation codes.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    // Reset value of the heap size register.
    localparam logic [COUNT_W-1:0] HEAP_RESET = COUNT_W'(NUM_BLOCKS);

    typedef struct packed {
        logic                func;
        logic [BYTES_W-1:0]  alloc_bytes;
        logic [OFFSET_W-1:0] free_offset;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [BLK_IDX_W-1:0] start_block;
        logic [COUNT_W-1:0]   block_count;
        logic [OFFSET_W-1:0]  data_offset;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan;
        logic mark;
        logic free_clr;
        logic out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_free;
        logic too_big;
        logic scan_end;
    } status_t;

    // Byte offset of the data area of a block.
    function automatic logic [OFFSET_W-1:0] data_offset_of(input logic [BLK_IDX_W-1:0] blk);
        logic [OFFSET_W-1:0] base;
        base = OFFSET_W'({blk, {BLOCK_SHIFT{1'b0}}});
        return base + OFFSET_W'(HEADER_BYTES);
    endfunction

endpackage

@@ rtl/bitmap_block_allocator.sv @@
// Top level of the bitmap first-fit block allocator.
// A pool of 256 blocks of 16 bytes is tracked by one map bit per block. An
// allocate request adds a 4-byte header, rounds up to whole blocks and takes
// the lowest run of free blocks within the heap size; a free request releases
// the run recorded at the block behind the given data offset, without
// checking it. One request is handled at a time. An allocate passes a check
// state, one scan step for each group of four map bits the first-fit scan
// walks, a mark state and a done state; the scan stops at the first fitting
// run and is skipped when the request is larger than the pool. A free passes
// the check state, a clear state that uses the registered read of the run
// length memory, and the done state. A new request is accepted while the
// previous response is still waiting in the output register; its own
// response then waits until that one is taken.
module bitmap_block_allocator (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  bba_pkg::req_t               s_req,
    output logic                        m_valid,
    input  logic                        m_ready,
    output bba_pkg::rsp_t               m_rsp,
    input  logic                        cfg_wen,
    input  logic [bba_pkg::COUNT_W-1:0] cfg_wdata
);

    bba_pkg::cmd_t    cmd;
    bba_pkg::status_t status;

    // Request sequencing.
    bba_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Map, memory and arithmetic.
    bba_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_req     (s_req),
        .m_rsp     (m_rsp),
        .cfg_wen   (cfg_wen),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

@@ rtl/bba_ctrl.sv @@
// Sequencing state machine for allocate and free requests.
module bba_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    input  bba_pkg::status_t  status,
    output bba_pkg::cmd_t     cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SCAN,
        ST_MARK,
        ST_FREE_CLR,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   m_valid_reg;
    logic   m_valid_next;
    logic   out_room;

    // The output register can take a new response when empty or being drained.
    assign out_room = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;

    // Next state and datapath commands.
    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg && !m_ready;
        cmd          = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                if (status.is_free) begin
                    state_next = ST_FREE_CLR;
                end else if (status.too_big) begin
                    state_next = ST_MARK;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
                if (status.scan_end) begin
                    state_next = ST_MARK;
                end
            end
            ST_MARK: begin
                cmd.mark   = 1'b1;
                state_next = ST_DONE;
            end
            ST_FREE_CLR: begin
                cmd.free_clr = 1'b1;
                state_next   = ST_DONE;
            end
            ST_DONE: begin
                if (out_room) begin
                    cmd.out_load = 1'b1;
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and output valid flag.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

@@ rtl/bba_datapath.sv @@
// Allocation map, run length memory, first-fit scan and response register.
module bba_datapath (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  bba_pkg::req_t               s_req,
    output bba_pkg::rsp_t               m_rsp,
    input  logic                        cfg_wen,
    input  logic [bba_pkg::COUNT_W-1:0] cfg_wdata,
    input  bba_pkg::cmd_t               cmd,
    output bba_pkg::status_t            status
);

    localparam int NB  = bba_pkg::NUM_BLOCKS;
    localparam int IW  = bba_pkg::BLK_IDX_W;
    localparam int CW  = bba_pkg::COUNT_W;
    localparam int NW  = bba_pkg::NEED_W;
    localparam int PW  = bba_pkg::POS_W;
    localparam int LW  = bba_pkg::LANE_W;

    bba_pkg::req_t  req_reg;
    bba_pkg::rsp_t  rsp_reg;
    bba_pkg::rsp_t  rsp_next;
    logic [NB-1:0]  map_reg;
    logic [CW-1:0]  heap_reg;
    logic [PW-1:0]  pos_reg;
    logic [CW-1:0]  run_reg;
    logic [CW-1:0]  run_next;
    logic           found_reg;
    logic [IW-1:0]  start_reg;
    logic [IW-1:0]  start_next;
    logic           hit;
    logic [CW-1:0]  len_reg;
    logic [CW-1:0]  rd_data_reg;
    logic [CW-1:0]  len_mem [NB];

    logic [NW-1:0]  need;
    logic [CW-1:0]  limit;
    logic [IW-1:0]  free_blk;
    logic [bba_pkg::OFFSET_W-1:0] free_base;
    logic           last_chunk;
    logic [NB-1:0]  mark_mask;
    logic [NB-1:0]  free_mask;

    // Blocks needed: header added, rounded up to whole blocks.
    assign need = NW'((15'(req_reg.alloc_bytes) + 15'(bba_pkg::HEADER_BYTES)
                       + 15'(bba_pkg::BLOCK_BYTES - 1)) >> bba_pkg::BLOCK_SHIFT);

    // Register values above the pool size act as the pool size.
    assign limit = (heap_reg > CW'(NB)) ? CW'(NB) : heap_reg;

    // Start block of a free, the offset is trusted.
    assign free_base = req_reg.free_offset - bba_pkg::OFFSET_W'(bba_pkg::HEADER_BYTES);
    assign free_blk  = free_base[bba_pkg::OFFSET_W-1 -: IW];

    // One scan step over a group of map bits, tracking the current free run.
    always_comb begin
        logic [IW-1:0] idx;
        run_next   = run_reg;
        start_next = start_reg;
        hit        = 1'b0;
        for (int j = 0; j < bba_pkg::SCAN_LANES; j++) begin
            idx = {pos_reg, LW'(j)};
            if (!hit && ({1'b0, idx} < limit)) begin
                if (!map_reg[idx]) begin
                    run_next = run_next + CW'(1);
                    if ({1'b0, run_next} == need) begin
                        hit        = 1'b1;
                        start_next = IW'({1'b0, idx} + CW'(1) - run_next);
                    end
                end else begin
                    run_next = '0;
                end
            end
        end
    end

    // The last group reaches the end of the usable pool.
    assign last_chunk = ({1'b0, pos_reg, {LW{1'b0}}} + CW'(bba_pkg::SCAN_LANES)) >= limit;

    // Range masks for marking and clearing the map; a free uses the length just read.
    always_comb begin
        logic [NW-1:0] mark_end;
        logic [NW:0]   free_end;
        mark_end = NW'(start_reg) + need;
        free_end = (NW+1)'(free_blk) + (NW+1)'(rd_data_reg);
        for (int k = 0; k < NB; k++) begin
            mark_mask[k] = (NW'(k) >= NW'(start_reg)) && (NW'(k) < mark_end);
            free_mask[k] = ((NW+1)'(k) >= (NW+1)'(free_blk)) && ((NW+1)'(k) < free_end);
        end
    end

    assign status.is_free  = (req_reg.func == bba_pkg::FUNC_FREE);
    assign status.too_big  = (need > NW'(limit));
    assign status.scan_end = hit || last_chunk;

    // Response contents for the finished request.
    always_comb begin
        rsp_next = '0;
        if (req_reg.func == bba_pkg::FUNC_FREE) begin
            rsp_next.ok          = 1'b1;
            rsp_next.start_block = free_blk;
            rsp_next.block_count = len_reg;
            rsp_next.data_offset = bba_pkg::data_offset_of(free_blk);
        end else if (found_reg) begin
            rsp_next.ok          = 1'b1;
            rsp_next.start_block = start_reg;
            rsp_next.block_count = CW'(need);
            rsp_next.data_offset = bba_pkg::data_offset_of(start_reg);
        end
    end

    assign m_rsp = rsp_reg;

    // Control registers: pool size and allocation map.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_reg <= bba_pkg::HEAP_RESET;
            map_reg  <= '0;
        end else begin
            if (cfg_wen) begin
                heap_reg <= cfg_wdata;
            end
            if (cmd.mark && found_reg) begin
                map_reg <= map_reg | mark_mask;
            end else if (cmd.free_clr) begin
                map_reg <= map_reg & ~free_mask;
            end
        end
    end

    // Request capture and scan progress.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_req;
            pos_reg   <= '0;
            run_reg   <= '0;
            found_reg <= 1'b0;
        end else if (cmd.scan) begin
            pos_reg   <= pos_reg + PW'(1);
            run_reg   <= run_next;
            start_reg <= start_next;
            if (hit) begin
                found_reg <= 1'b1;
            end
        end
        if (cmd.free_clr) begin
            len_reg <= rd_data_reg;
        end
        if (cmd.out_load) begin
            rsp_reg <= rsp_next;
        end
    end

    // Run length memory: one write port, registered read at the free block.
    always_ff @(posedge aclk) begin
        rd_data_reg <= len_mem[free_blk];
        if (cmd.mark && found_reg) begin
            len_mem[start_reg] <= CW'(need);
        end else if (cmd.free_clr) begin
            len_mem[free_blk] <= '0;
        end
    end

endmodule
